[rtl/swm_pkg.sv]
// swm_pkg: shared types and codes for the star wildcard matcher.
// No dependencies; every other file of the block refers to it by scoped name.

package swm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEF = 64;

    // Item commands
    localparam logic [1:0] CMD_PATTERN = 2'd0;
    localparam logic [1:0] CMD_SUBJECT = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;

    // Report status codes
    localparam logic [1:0] STATUS_NO_MATCH = 2'd0;
    localparam logic [1:0] STATUS_MATCH    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Special bytes
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    // Input transaction payload
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_byte;
        logic       pattern_start;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [1:0] status;
    } t_out_item;

    // One update request to the position engine, already qualified by the handshake
    typedef struct packed {
        logic       pat_wr;
        logic       subj_step;
        logic       report;
        logic       pattern_start;
        logic [7:0] char_byte;
    } t_nfa_req;

endpackage

[rtl/swm_if.sv]
// swm_if: valid/ready stream interfaces for the matcher's input and output channels.
// Depends on swm_pkg for the payload types.

interface swm_in_if;
    logic              valid;
    logic              ready;
    swm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swm_out_if;
    logic               valid;
    logic               ready;
    swm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/swm_nfa.sv]
// swm_nfa: pattern store and active-position vector, updated once per request.
// Depends on swm_pkg. Runs of '*' are stored as a single '*', so star closure is one step.

module swm_nfa #(
    parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swm_pkg::t_nfa_req i_req,
    output logic [1:0]        o_status
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = $clog2(PATTERN_MAX);

    // Pattern bytes (compacted) and lengths
    logic [7:0]         r_pat [PATTERN_MAX];
    logic [LEN_W-1:0]   r_clen;       // compacted length
    logic [LEN_W-1:0]   r_rlen;       // raw byte count, for capacity
    logic               r_ovf;
    logic               r_last_star;

    // Subject state; r_act is kept before star closure
    logic [PATTERN_MAX:0] r_act;
    logic                 r_started;
    logic                 r_hidden;

    logic [PATTERN_MAX-1:0] w_live;
    logic [PATTERN_MAX-1:0] w_star;
    logic [PATTERN_MAX-1:0] w_hit;
    logic [PATTERN_MAX:0]   w_cur;
    logic [PATTERN_MAX:0]   w_step;
    logic [PATTERN_MAX:0]   w_restart;

    logic [LEN_W-1:0]       w_base_clen;
    logic [LEN_W-1:0]       w_base_rlen;
    logic                   w_base_ovf;
    logic                   w_base_last_star;
    logic                   w_room;
    logic                   w_in_star;
    logic                   w_store;

    // Per-position decode
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_live[i] = LEN_W'(i) < r_clen;
            w_star[i] = w_live[i] && (r_pat[i] == swm_pkg::STAR_BYTE);
            w_hit[i]  = w_live[i] && (r_pat[i] != swm_pkg::STAR_BYTE)
                        && (r_pat[i] == i_req.char_byte);
        end
    end

    // One-step star closure (no two stars are adjacent in the store)
    always_comb begin
        w_cur[0] = r_act[0];
        for (int k = 1; k <= PATTERN_MAX; k++) begin
            w_cur[k] = r_act[k] | (r_act[k-1] & w_star[k-1]);
        end
    end

    // Advance every active position by one subject byte
    always_comb begin
        w_step[0] = w_cur[0] & w_star[0];
        for (int k = 1; k < PATTERN_MAX; k++) begin
            w_step[k] = (w_cur[k] & w_star[k]) | (w_cur[k-1] & w_hit[k-1]);
        end
        w_step[PATTERN_MAX] = w_cur[PATTERN_MAX-1] & w_hit[PATTERN_MAX-1];
    end

    assign w_restart = {{PATTERN_MAX{1'b0}}, 1'b1};

    // Verdict for a report
    always_comb begin
        if (r_ovf) begin
            o_status = swm_pkg::STATUS_OVERFLOW;
        end else if (w_cur[r_clen] && !r_hidden) begin
            o_status = swm_pkg::STATUS_MATCH;
        end else begin
            o_status = swm_pkg::STATUS_NO_MATCH;
        end
    end

    // Pattern append: start clears first, repeated stars collapse
    assign w_base_clen      = i_req.pattern_start ? '0   : r_clen;
    assign w_base_rlen      = i_req.pattern_start ? '0   : r_rlen;
    assign w_base_ovf       = i_req.pattern_start ? 1'b0 : r_ovf;
    assign w_base_last_star = i_req.pattern_start ? 1'b0 : r_last_star;
    assign w_room           = w_base_rlen < LEN_W'(PATTERN_MAX);
    assign w_in_star        = i_req.char_byte == swm_pkg::STAR_BYTE;
    assign w_store          = i_req.pat_wr && w_room && !(w_in_star && w_base_last_star);

    // Pattern byte storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_pat[w_base_clen[IDX_W-1:0]] <= i_req.char_byte;
        end
    end

    // Pattern bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clen      <= '0;
            r_rlen      <= '0;
            r_ovf       <= 1'b0;
            r_last_star <= 1'b0;
        end else if (i_req.pat_wr) begin
            if (w_room) begin
                r_rlen      <= w_base_rlen + LEN_W'(1);
                r_ovf       <= w_base_ovf;
                r_last_star <= w_in_star;
                r_clen      <= w_store ? w_base_clen + LEN_W'(1) : w_base_clen;
            end else begin
                r_rlen      <= w_base_rlen;
                r_ovf       <= 1'b1;
                r_last_star <= w_base_last_star;
                r_clen      <= w_base_clen;
            end
        end
    end

    // Subject state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= w_restart;
            r_started <= 1'b0;
            r_hidden  <= 1'b0;
        end else if (i_req.pat_wr || i_req.report) begin
            r_act     <= w_restart;
            r_started <= 1'b0;
            r_hidden  <= 1'b0;
        end else if (i_req.subj_step) begin
            r_act     <= w_step;
            r_started <= 1'b1;
            // hidden name needs a pattern that starts with a dot
            if (!r_started && (i_req.char_byte == swm_pkg::DOT_BYTE)
                && ((r_clen == '0) || (r_pat[0] != swm_pkg::DOT_BYTE))) begin
                r_hidden <= 1'b1;
            end
        end
    end

    // Compacted length never exceeds the raw count
    a_clen_le_rlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clen <= r_rlen)
        else $error("compacted pattern length above raw length");

    // Overflow only once the raw count has hit capacity
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_rlen == LEN_W'(PATTERN_MAX)))
        else $error("overflow flagged below capacity");

    // Hidden block only after the first subject byte
    a_hidden_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hidden |-> r_started)
        else $error("hidden flag set with no subject started");

endmodule

[rtl/star_wildcard_matcher_core.sv]
// Glob matcher with '*' wildcards: top level with input and result registers.
// Depends on swm_pkg, swm_if (swm_in_if, swm_out_if) and swm_nfa.
//
// The block accepts one transaction per clock cycle, sustained, on every command
// (pattern bytes, subject bytes and report requests) while no report is stalled. An
// accepted item lands in an input register; from there the position engine updates
// the full active vector for all pattern positions at once, and a report's status
// is written to the result register, from which it is presented. The input side
// keeps taking items while a status waits to be taken; only a second report behind
// an untaken status stalls. Pattern capacity is PATTERN_MAX bytes; longer patterns
// report status 2 until a new pattern starts.

module star_wildcard_matcher_core #(
    parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swm_in_if.sink      i_in,
    swm_out_if.source   o_out
);

    logic               r_in_valid;
    swm_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    swm_pkg::t_out_item r_out_item;

    logic               w_advance;
    logic               w_is_report;
    swm_pkg::t_nfa_req  w_req;
    logic [1:0]         w_status;

    // Stage advance: only a report needs room in the result register
    assign w_is_report = r_in_item.command == swm_pkg::CMD_REPORT;
    assign w_advance   = r_in_valid && (!w_is_report || !r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // Decode the staged item into an engine request
    always_comb begin
        w_req.pat_wr        = 1'b0;
        w_req.subj_step     = 1'b0;
        w_req.report        = 1'b0;
        w_req.pattern_start = r_in_item.pattern_start;
        w_req.char_byte     = r_in_item.char_byte;
        case (r_in_item.command)
            swm_pkg::CMD_PATTERN: w_req.pat_wr    = w_advance;
            swm_pkg::CMD_SUBJECT: w_req.subj_step = w_advance;
            swm_pkg::CMD_REPORT:  w_req.report    = w_advance;
            default: begin
                // unused command: consumed, no effect
            end
        endcase
    end

    swm_nfa #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_nfa (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_status (w_status)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_req.report) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req.report) begin
            r_out_item.status <= w_status;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // A report that leaves the input stage always produces a result next cycle
    a_report_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_report) |=> r_out_valid)
        else $error("report advanced without a result");

    // A staged report behind an untaken result blocks new input
    a_report_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_is_report && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a report is stalled");

    // The staged item is never lost: it stays until it advances
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("staged item dropped before advancing");

endmodule

[test/tb_star_wildcard_matcher_core.sv]
// Self-checking testbench for star_wildcard_matcher_core: glob patterns with '*' loaded
// byte by byte, subjects streamed against them, verdicts checked against a local predictor.
// Depends on swm_pkg, swm_if and the matcher RTL.
`timescale 1ns / 100ps

module tb_star_wildcard_matcher_core;

    localparam int PAT_CAP      = swm_pkg::PATTERN_MAX_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_LEN = 400;
    localparam int HOLD_OFF_AT  = 30;

    // Unused command code, the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swm_in_if  in_if ();
    swm_out_if out_if ();

    star_wildcard_matcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Directed rows; lit marks a status that is typed in rather than predicted
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] chr;
        logic       start;
        logic       lit;
        logic [1:0] lit_status;
    } t_dir_row;

    t_dir_row dir_rows [25] = '{
        // empty pattern, empty name
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b1, swm_pkg::STATUS_MATCH},
        '{swm_pkg::CMD_SUBJECT, CH_A,               1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        // empty pattern, "a"
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b1, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_PATTERN, swm_pkg::STAR_BYTE, 1'b1, 1'b0, swm_pkg::STATUS_NO_MATCH},
        // "*" vs empty name
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b1, swm_pkg::STATUS_MATCH},
        '{swm_pkg::CMD_SUBJECT, swm_pkg::DOT_BYTE,  1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        // hidden name vs "*"
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b1, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, 8'hFF,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, 8'h00,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        // "*" takes anything
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b1, swm_pkg::STATUS_MATCH},
        '{swm_pkg::CMD_PATTERN, CH_A,               1'b1, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_PATTERN, swm_pkg::STAR_BYTE, 1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_PATTERN, 8'hFF,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, CH_A,               1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, 8'h00,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, 8'hFF,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, CH_A,               1'b1, 1'b0, swm_pkg::STATUS_NO_MATCH},
        // abandons the name
        '{swm_pkg::CMD_PATTERN, swm_pkg::DOT_BYTE,  1'b1, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_SUBJECT, swm_pkg::DOT_BYTE,  1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{CMD_UNUSED,           8'hFF,              1'b1, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_PATTERN, swm_pkg::STAR_BYTE, 1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH},
        '{swm_pkg::CMD_REPORT,  8'h00,              1'b0, 1'b0, swm_pkg::STATUS_NO_MATCH}
    };

    // Predictor state
    logic [7:0]   pat_mem [PAT_CAP];
    int           pat_len;
    bit           pat_ovf;
    bit [PAT_CAP:0] live_pos;
    bit           subj_begun;
    bit           dot_blocked;

    logic [1:0] expected_status_q [$];
    int         err_cnt;
    int         items_sent;
    int         results_seen;
    bit         tx_burst;
    bit         rx_burst;

    // Let activity flow through '*' positions (a star may match nothing)
    function automatic bit [PAT_CAP:0] star_spread(input bit [PAT_CAP:0] v);
        for (int i = 0; i < pat_len; i++)
            if (v[i] && pat_mem[i] == swm_pkg::STAR_BYTE)
                v[i + 1] = 1'b1;
        return v;
    endfunction

    task automatic name_restart();
        live_pos    = '0;
        live_pos[0] = 1'b1;
        subj_begun  = 1'b0;
        dot_blocked = 1'b0;
    endtask

    // Advance the predicted matcher by one transaction
    task automatic glob_predict(input swm_pkg::t_in_item it, output bit has_res,
                                output logic [1:0] st);
        bit [PAT_CAP:0] cur;
        bit [PAT_CAP:0] nxt;
        has_res = 1'b0;
        st      = swm_pkg::STATUS_NO_MATCH;
        case (it.command)
            swm_pkg::CMD_PATTERN: begin
                if (it.pattern_start) begin
                    pat_len = 0;
                    pat_ovf = 1'b0;
                end
                if (pat_len < PAT_CAP) begin
                    pat_mem[pat_len] = it.char_byte;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                name_restart();
            end
            swm_pkg::CMD_SUBJECT: begin
                if (!subj_begun) begin
                    subj_begun = 1'b1;
                    if (it.char_byte == swm_pkg::DOT_BYTE
                        && (pat_len == 0 || pat_mem[0] != swm_pkg::DOT_BYTE))
                        dot_blocked = 1'b1;
                end
                cur = star_spread(live_pos);
                nxt = '0;
                for (int i = 0; i < pat_len; i++) begin
                    if (cur[i]) begin
                        if (pat_mem[i] == swm_pkg::STAR_BYTE)
                            nxt[i] = 1'b1;
                        else if (pat_mem[i] == it.char_byte)
                            nxt[i + 1] = 1'b1;
                    end
                end
                live_pos = star_spread(nxt);
            end
            swm_pkg::CMD_REPORT: begin
                has_res = 1'b1;
                if (pat_ovf) begin
                    st = swm_pkg::STATUS_OVERFLOW;
                end else begin
                    cur = star_spread(live_pos);
                    st  = (cur[pat_len] && !dot_blocked) ? swm_pkg::STATUS_MATCH
                                                         : swm_pkg::STATUS_NO_MATCH;
                end
                name_restart();
            end
            default: ;
        endcase
    endtask

    function automatic swm_pkg::t_in_item mk_item(input logic [1:0] cmd,
                                                  input logic [7:0] chr,
                                                  input logic start);
        swm_pkg::t_in_item it;
        it.command       = cmd;
        it.char_byte     = chr;
        it.pattern_start = start;
        return it;
    endfunction

    function automatic logic [7:0] pick_pat_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5:       return swm_pkg::DOT_BYTE;
            6, 7:    return swm_pkg::STAR_BYTE;
            8:       return 8'($urandom_range(0, 255));
            default: return CH_C;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_A;
            3, 4:    return CH_B;
            5:       return CH_C;
            6:       return swm_pkg::DOT_BYTE;
            7:       return swm_pkg::STAR_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one transaction; on acceptance update the predictor
    task automatic send_item(input swm_pkg::t_in_item it, input bit lit,
                             input logic [1:0] lit_st);
        int gap;
        bit has_res;
        logic [1:0] st;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        glob_predict(it, has_res, st);
        if (has_res)
            expected_status_q.push_back(lit ? lit_st : st);
        if (it.command != CMD_UNUSED)
            items_sent++;
    endtask

    // One name built mostly to fit the current pattern, then a report
    task automatic run_name();
        logic [7:0] name_q [$];
        int n;
        if (pat_ovf || $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 6)) name_q.push_back(pick_name_byte());
        end else begin
            for (int i = 0; i < pat_len; i++) begin
                if (pat_mem[i] == swm_pkg::STAR_BYTE)
                    repeat ($urandom_range(0, 3)) name_q.push_back(pick_name_byte());
                else
                    name_q.push_back(pat_mem[i]);
            end
        end
        // Occasional damage so that near misses show up
        if ($urandom_range(0, 3) == 0) begin
            n = name_q.size();
            case ($urandom_range(0, 3))
                0: if (n != 0) name_q[$urandom_range(0, n - 1)] = pick_name_byte();
                1: name_q.push_back(pick_name_byte());
                2: if (n != 0) void'(name_q.pop_front());
                default: name_q.push_front(swm_pkg::DOT_BYTE);
            endcase
        end
        foreach (name_q[i]) begin
            case ($urandom_range(0, 49))
                0: send_item(mk_item(CMD_UNUSED, 8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1))),
                             1'b0, swm_pkg::STATUS_NO_MATCH);
                1: send_item(mk_item(swm_pkg::CMD_PATTERN, pick_pat_byte(),
                                     1'($urandom_range(0, 1))),
                             1'b0, swm_pkg::STATUS_NO_MATCH);
                default: ;
            endcase
            send_item(mk_item(swm_pkg::CMD_SUBJECT, name_q[i], 1'($urandom_range(0, 1))),
                      1'b0, swm_pkg::STATUS_NO_MATCH);
        end
        send_item(mk_item(swm_pkg::CMD_REPORT, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1))),
                  1'b0, swm_pkg::STATUS_NO_MATCH);
    endtask

    // Stimulus
    initial begin
        int plen;
        int goal;
        int r;
        bit append;
        bit first_group;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        err_cnt      = 0;
        items_sent   = 0;
        results_seen = 0;
        tx_burst     = 1'b0;
        pat_len      = 0;
        pat_ovf      = 1'b0;
        name_restart();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(mk_item(dir_rows[i].cmd, dir_rows[i].chr, dir_rows[i].start),
                      dir_rows[i].lit, dir_rows[i].lit_status);

        goal        = items_sent + RANDOM_ITEMS;
        first_group = 1'b1;
        while (items_sent < goal) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            // Sender pause until every verdict is back
            if (first_group || $urandom_range(0, 9) == 0) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                wait (expected_status_q.size() == 0);
            end
            first_group = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 2)
                plen = $urandom_range(PAT_CAP + 1, PAT_CAP + 6);
            else if (r < 5)
                plen = PAT_CAP;
            else
                plen = $urandom_range(1, 8);
            append = (!pat_ovf && pat_len + plen < 50 && $urandom_range(0, 6) == 0);
            for (int k = 0; k < plen; k++)
                send_item(mk_item(swm_pkg::CMD_PATTERN, pick_pat_byte(), k == 0 && !append),
                          1'b0, swm_pkg::STATUS_NO_MATCH);
            repeat ($urandom_range(1, 6)) run_name();
        end
        @(negedge i_clk);
        in_if.valid <= 1'b0;

        wait (expected_status_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, one long hold-off, check against oldest expectation
    initial begin
        int stall;
        logic [1:0] exp_st;
        out_if.ready = 1'b0;
        rx_burst     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (results_seen % 20 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            if (results_seen == HOLD_OFF_AT)
                stall = HOLD_OFF_LEN;
            else
                stall = rx_burst ? 0 : $urandom_range(0, 14);
            @(negedge i_clk);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            results_seen++;
            if (expected_status_q.size() == 0) begin
                $error("status with no transaction pending: got %0d", out_if.data.status);
                err_cnt++;
            end else begin
                exp_st = expected_status_q.pop_front();
                if (out_if.data.status !== exp_st) begin
                    $error("status mismatch: expected %0d, got %0d", exp_st,
                           out_if.data.status);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/swm_pkg.sv
rtl/swm_if.sv
rtl/swm_nfa.sv
rtl/star_wildcard_matcher_core.sv
test/tb_star_wildcard_matcher_core.sv
